// ----- sv/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants of the radio frame checker
// Holds the input and result item structs, the frame marker bytes, the status
// codes and the register map of the configuration port.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int STAT_W = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] START_MARK = 8'h2A;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h26;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_START   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_END     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_MINE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SUM     = 3'd4;
    localparam logic [STAT_W-1:0] ST_RX_FAILED   = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Word index of each register (byte address divided by four).
    localparam logic REG_OWN_ADDRESS = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              first_of_packet;
        logic              last_of_packet;
        logic              rx_error;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] source_address;
        logic [BYTE_W-1:0] payload_length;
        logic              last;
    } t_out_item;

endpackage

// ----- sv/radio_frame_checker_core.sv -----
// ----------------------------------------------------------------------------
// radio_frame_checker_core: byte-serial checker for received radio frames
// Parses '*', source, destination, length, payload, '&', checksum; forwards
// payload bytes and closes each frame with one status item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                     Payload
//  -------  ---------  ----------------------------  --------------------------
//  in       input      i_in_valid / o_in_stall       i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall     o_out_data (t_out_item)
//  cfg      input      APB psel/penable/pwrite       pwdata, paddr, prdata
//
//  The block takes one item per clock cycle while o_in_stall is low. An accepted
//  item is held in the input register, where the parser state is updated; its
//  result (if any) then moves into the output register, which drives o_out_valid.
//  Reset (i_rst_n low at a rising edge) empties both registers, clears the
//  parser state and sets it to wait for the first byte of a packet.
//  While the output register is stalled, one more item is still taken into the
//  input register; only then does o_in_stall rise.
//
module radio_frame_checker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rfc_pkg::t_in_item               i_in_data,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rfc_pkg::t_out_item              o_out_data,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfc_pkg::PADDR_W-1:0]     paddr,
    input  logic [rfc_pkg::PDATA_W-1:0]     pwdata,
    output logic [rfc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [rfc_pkg::BYTE_W-1:0] r_own_address;
    logic                       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[rfc_pkg::PADDR_W-1] == rfc_pkg::REG_OWN_ADDRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_own_address <= pwdata[rfc_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_hit) begin
            prdata[rfc_pkg::BYTE_W-1:0] = r_own_address;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the parser, output register holds
    // the result. The parser step happens whenever the input register holds an item
    // and the output register can take a new value, whether or not it produces a result.
    // ------------------------------------------------------------------
    logic                r_in_valid;
    rfc_pkg::t_in_item   r_in;
    logic                r_out_valid;
    rfc_pkg::t_out_item  r_out;
    logic                out_free;
    logic                advance;
    logic                in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [rfc_pkg::POS_W-1:0]  r_pos;
    logic [rfc_pkg::BYTE_W-1:0] r_len;
    logic [rfc_pkg::BYTE_W-1:0] r_sender;
    logic                       r_to_me;
    logic [rfc_pkg::BYTE_W-1:0] r_sum;
    logic                       r_done;
    logic                       r_start_bad;
    logic                       r_end_bad;

    logic [rfc_pkg::POS_W-1:0]  n_pos;
    logic [rfc_pkg::BYTE_W-1:0] n_len;
    logic [rfc_pkg::BYTE_W-1:0] n_sender;
    logic                       n_to_me;
    logic [rfc_pkg::BYTE_W-1:0] n_sum;
    logic                       n_done;
    logic                       n_start_bad;
    logic                       n_end_bad;

    // A first_of_packet byte starts from a cleared frame; these are the
    // values the step works from.
    logic [rfc_pkg::POS_W-1:0]  base_pos;
    logic [rfc_pkg::BYTE_W-1:0] base_len;
    logic [rfc_pkg::BYTE_W-1:0] base_sender;
    logic                       base_to_me;
    logic [rfc_pkg::BYTE_W-1:0] base_sum;
    logic                       base_start_bad;
    logic                       base_end_bad;

    logic [rfc_pkg::POS_W-1:0]  len_ext;
    logic [rfc_pkg::BYTE_W-1:0] b;
    logic                       active;
    logic                       emit_payload;
    logic                       at_checksum;
    logic                       at_end_mark;
    logic                       closes;
    logic [rfc_pkg::STAT_W-1:0] status;
    logic                       has_result;
    rfc_pkg::t_out_item         n_out;

    always_comb begin
        b      = r_in.byte_value;
        active = !r_in.rx_error && (r_in.first_of_packet || !r_done);

        if (r_in.first_of_packet) begin
            base_pos       = '0;
            base_len       = '0;
            base_sender    = '0;
            base_to_me     = 1'b0;
            base_sum       = '0;
            base_start_bad = 1'b0;
            base_end_bad   = 1'b0;
        end else begin
            base_pos       = r_pos;
            base_len       = r_len;
            base_sender    = r_sender;
            base_to_me     = r_to_me;
            base_sum       = r_sum;
            base_start_bad = r_start_bad;
            base_end_bad   = r_end_bad;
        end

        len_ext = {1'b0, base_len};

        n_len        = base_len;
        n_sender     = base_sender;
        n_to_me      = base_to_me;
        n_sum        = base_sum;
        n_start_bad  = base_start_bad;
        n_end_bad    = base_end_bad;
        emit_payload = 1'b0;
        at_checksum  = 1'b0;
        at_end_mark  = 1'b0;

        if (base_pos == 9'd0) begin
            n_start_bad = (b != rfc_pkg::START_MARK);
        end else if (base_pos == 9'd1) begin
            n_sender = b;
            n_sum    = base_sum + b;
        end else if (base_pos == 9'd2) begin
            n_to_me = (b == r_own_address);
            n_sum   = base_sum + b;
        end else if (base_pos == 9'd3) begin
            n_len = b;
            if (b != '0) begin
                n_sum = base_sum + b;
            end
        end else if (base_pos <= len_ext + 9'd3) begin
            // Payload: the checksum covers all but the last payload byte.
            if (base_pos <= len_ext + 9'd2) begin
                n_sum = base_sum + b;
            end
            emit_payload = !base_start_bad;
        end else if (base_pos == len_ext + 9'd4) begin
            n_end_bad   = (b != rfc_pkg::END_MARK);
            at_end_mark = 1'b1;
        end else begin
            at_checksum = 1'b1;
        end

        // Status in priority order. At an early packet end the checksum is
        // missing, so a frame that passes the other checks still fails it.
        if (n_start_bad) begin
            status = rfc_pkg::ST_BAD_START;
        end else if (n_end_bad || (!at_checksum && !at_end_mark)) begin
            status = rfc_pkg::ST_BAD_END;
        end else if (!n_to_me) begin
            status = rfc_pkg::ST_NOT_MINE;
        end else if (!at_checksum || (b != base_sum)) begin
            status = rfc_pkg::ST_BAD_SUM;
        end else begin
            status = rfc_pkg::ST_OK;
        end

        closes = at_checksum || r_in.last_of_packet;

        n_pos  = r_pos;
        n_done = r_done;
        if (r_in.rx_error) begin
            n_done = 1'b1;
        end else if (active) begin
            n_done = closes;
            if (!closes) begin
                n_pos = base_pos + 9'd1;
            end
        end

        n_out.kind           = rfc_pkg::KIND_STATUS;
        n_out.payload_byte   = '0;
        n_out.status         = status;
        n_out.source_address = n_sender;
        n_out.payload_length = n_len;
        n_out.last           = 1'b1;
        has_result           = 1'b0;
        if (r_in.rx_error) begin
            n_out.status         = rfc_pkg::ST_RX_FAILED;
            n_out.source_address = '0;
            n_out.payload_length = '0;
            has_result           = 1'b1;
        end else if (active && closes) begin
            has_result = 1'b1;
        end else if (active && emit_payload) begin
            n_out.kind         = rfc_pkg::KIND_PAYLOAD;
            n_out.payload_byte = b;
            n_out.status       = rfc_pkg::ST_OK;
            n_out.last         = 1'b0;
            has_result         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_sender    <= '0;
            r_to_me     <= 1'b0;
            r_sum       <= '0;
            r_done      <= 1'b1;
            r_start_bad <= 1'b0;
            r_end_bad   <= 1'b0;
        end else if (advance && (active || r_in.rx_error)) begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sender    <= n_sender;
            r_to_me     <= n_to_me;
            r_sum       <= n_sum;
            r_done      <= n_done;
            r_start_bad <= n_start_bad;
            r_end_bad   <= n_end_bad;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- test/radio_frame_checker_core_test.sv -----
// ----------------------------------------------------------------------------
// radio_frame_checker_core_test: self-checking bench for the frame checker
// Feeds whole frames, broken frames, truncated packets, reception errors and
// stray bytes through the input channel. A behavioral copy of the parser
// predicts every payload and status item, which the output monitor checks in
// order. Six phases change the node address and the idling pattern.
// ----------------------------------------------------------------------------
module radio_frame_checker_core_test;

    import rfc_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int SHOWN_FAILURES  = 10;
    localparam int BYTES_PER_PHASE = 45;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASES          = 6;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_W-1:0]    paddr     = '0;
    logic [PDATA_W-1:0]    pwdata    = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    radio_frame_checker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and the items the parser copy expects back.
    t_in_item  rx_bytes_pending[$];
    t_out_item expected_reports[$];

    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  in_taken        = 1'b0;
    int  fail_count      = 0;
    int  quiet_cycles    = 0;
    int  bytes_accepted  = 0;
    int  payload_seen    = 0;
    int  frames_queued   = 0;
    int  status_hits[8];

    // Testbench copy of the node address register.
    logic [7:0] own_addr_cfg = 8'h00;

    // Parser state of the behavioral copy, at its reset values.
    logic [8:0] frame_pos    = '0;
    logic [7:0] frame_len    = '0;
    logic [7:0] frame_src    = '0;
    logic [7:0] frame_sum    = '0;
    bit         frame_for_me = 1'b0;
    bit         frame_idle   = 1'b1;
    bit         start_wrong  = 1'b0;
    bit         end_wrong    = 1'b0;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic string fmt_result(input t_out_item r);
        return $sformatf("kind %0d byte %02h status %0d src %02h len %02h last %0d",
                         r.kind, r.payload_byte, r.status, r.source_address,
                         r.payload_length, r.last);
    endfunction

    // Advances the parser copy by one accepted byte. Returns 1 when the byte
    // produces an item, which is then left in res.
    function automatic bit parse_rx_byte(input t_in_item it, output t_out_item res);
        int         p;
        int         len;
        bit         closing;
        bit         end_ok;
        bit         sum_ok;
        bit         fwd;
        logic [7:0] b;
        res     = '0;
        closing = 1'b0;
        end_ok  = 1'b0;
        sum_ok  = 1'b0;
        fwd     = 1'b0;
        b       = it.byte_value;
        // A failed reception aborts whatever is in progress.
        if (it.rx_error) begin
            frame_idle = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_RX_FAILED;
            res.last   = 1'b1;
            return 1'b1;
        end
        if (it.first_of_packet) begin
            frame_pos    = '0;
            frame_len    = '0;
            frame_src    = '0;
            frame_sum    = '0;
            frame_for_me = 1'b0;
            start_wrong  = 1'b0;
            end_wrong    = 1'b0;
            frame_idle   = 1'b0;
        end else if (frame_idle) begin
            return 1'b0;
        end
        p   = frame_pos;
        len = frame_len;
        if (p == 0) begin
            start_wrong = (b != START_MARK);
        end else if (p == 1) begin
            frame_src = b;
            frame_sum += b;
        end else if (p == 2) begin
            frame_for_me = (b == own_addr_cfg);
            frame_sum += b;
        end else if (p == 3) begin
            frame_len = b;
            frame_sum += b;
        end else if (p <= 3 + len) begin
            // The last payload byte sits outside the summed span.
            if (p <= 2 + len) begin
                frame_sum += b;
            end
            fwd = !start_wrong;
        end else if (p == 4 + len) begin
            end_wrong = (b != END_MARK);
        end else begin
            closing = 1'b1;
            end_ok  = !end_wrong;
            sum_ok  = (b == frame_sum);
        end
        // A packet that ends before the checksum never has a good sum.
        if (!closing && it.last_of_packet) begin
            closing = 1'b1;
            end_ok  = (p == 4 + len) && !end_wrong;
        end
        res.source_address = frame_src;
        res.payload_length = frame_len;
        if (closing) begin
            frame_idle = 1'b1;
            res.kind   = KIND_STATUS;
            res.last   = 1'b1;
            if (start_wrong) begin
                res.status = ST_BAD_START;
            end else if (!end_ok) begin
                res.status = ST_BAD_END;
            end else if (!frame_for_me) begin
                res.status = ST_NOT_MINE;
            end else if (!sum_ok) begin
                res.status = ST_BAD_SUM;
            end else begin
                res.status = ST_OK;
            end
            return 1'b1;
        end
        frame_pos = frame_pos + 9'd1;
        if (fwd) begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Driver: a new byte is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (rx_bytes_pending.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= rx_bytes_pending.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: checks results, feeds accepted bytes to the parser copy and
    // watches for a stuck handshake.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit        got_out;
        if (i_rst_n) begin
            got_out  = out_valid && !out_stall;
            in_taken = in_valid && !in_stall;
            if (got_out) begin
                if (out_data.kind == KIND_PAYLOAD) begin
                    payload_seen++;
                end else begin
                    status_hits[out_data.status]++;
                end
                if (expected_reports.size() == 0) begin
                    note_failure({"unexpected item: ", fmt_result(out_data)});
                end else begin
                    want = expected_reports.pop_front();
                    if (out_data.kind !== want.kind ||
                        out_data.payload_byte !== want.payload_byte ||
                        out_data.status !== want.status ||
                        out_data.source_address !== want.source_address ||
                        out_data.payload_length !== want.payload_length ||
                        out_data.last !== want.last) begin
                        note_failure({"expected ", fmt_result(want),
                                      " / got ", fmt_result(out_data)});
                    end
                end
            end
            if (in_taken) begin
                bytes_accepted++;
                if (parse_rx_byte(in_data, want)) begin
                    expected_reports.push_back(want);
                end
            end
            if (got_out || in_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Timeout: no handshake for %0d cycles, %0d items outstanding",
                             STALL_LIMIT, expected_reports.size());
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            note_failure($sformatf("register read at %0d: expected %08h, got %08h",
                                   addr, want, got));
        end
    endtask

    task automatic set_own_address(input logic [7:0] value);
        reg_write(PADDR_W'({REG_OWN_ADDRESS, 2'b00}), PDATA_W'(value));
        own_addr_cfg = value;
        reg_check(PADDR_W'({REG_OWN_ADDRESS, 2'b00}), PDATA_W'(value));
    endtask

    task automatic push_byte(input logic [7:0] b, input bit first, input bit last,
                             input bit err);
        t_in_item it;
        it.byte_value      = b;
        it.first_of_packet = first;
        it.last_of_packet  = last;
        it.rx_error        = err;
        rx_bytes_pending.push_back(it);
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] r;
        r = 8'($urandom_range(0, 254));
        return (r >= v) ? r + 8'd1 : r;
    endfunction

    // Queues one frame of the given length with random content. Most frames
    // are well formed; some carry a wrong start, end marker, address or sum,
    // and some are cut short, aborted by a reception error or dropped.
    task automatic queue_frame(input int len);
        logic [7:0] fb[$];
        logic [7:0] sum;
        int         n;
        int         ending;
        int         stop_at;
        fb.delete();
        sum = '0;
        frames_queued++;
        fb.push_back(($urandom_range(0, 99) < 10) ? other_than(START_MARK) : START_MARK);
        fb.push_back(8'($urandom));
        fb.push_back(($urandom_range(0, 99) < 12) ? other_than(own_addr_cfg) : own_addr_cfg);
        fb.push_back(8'(len));
        repeat (len) fb.push_back(8'($urandom));
        for (int i = 1; i <= 2 + len; i++) begin
            sum += fb[i];
        end
        fb.push_back(($urandom_range(0, 99) < 10) ? other_than(END_MARK) : END_MARK);
        fb.push_back(($urandom_range(0, 99) < 10) ? other_than(sum) : sum);
        n      = fb.size();
        ending = $urandom_range(0, 99);
        if (ending < 80) begin
            // Complete frame; the radio usually flags the checksum as last.
            for (int i = 0; i < n; i++) begin
                push_byte(fb[i], i == 0, (i == n - 1) && ($urandom_range(0, 9) != 0), 1'b0);
            end
        end else if (ending < 90) begin
            stop_at = $urandom_range(0, n - 2);
            for (int i = 0; i <= stop_at; i++) begin
                push_byte(fb[i], i == 0, i == stop_at, 1'b0);
            end
        end else if (ending < 95) begin
            stop_at = $urandom_range(0, n - 1);
            for (int i = 0; i < stop_at; i++) begin
                push_byte(fb[i], i == 0, 1'b0, 1'b0);
            end
            push_byte(8'($urandom), (stop_at == 0) ? 1'b1 : 1'($urandom), 1'($urandom), 1'b1);
        end else begin
            // Dropped: the next start byte discards this frame silently.
            stop_at = $urandom_range(1, n - 1);
            for (int i = 0; i < stop_at; i++) begin
                push_byte(fb[i], i == 0, 1'b0, 1'b0);
            end
        end
    endtask

    // Lets every queued byte through and every expected item out, then gives
    // an ignored byte still in the pipeline time to drain.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (rx_bytes_pending.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] addr_plan[PHASES];
        int         phase_bytes;
        int         queued_prior;
        addr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h00, START_MARK, 8'($urandom)};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Receiver stalls often, then the sender idles often, then back-to-back traffic.
            sender_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 65 : 0;
            recv_stall_pct  = (ph < 2) ? 65 : (ph < 4) ? 15 : 0;
            if (ph == 0) begin
                reg_check(PADDR_W'({REG_OWN_ADDRESS, 2'b00}), '0);
                // Shortest good frame: the sum covers source and destination.
                push_byte(START_MARK, 1'b1, 1'b0, 1'b0);
                push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(END_MARK, 1'b0, 1'b0, 1'b0);
                push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
                // Good two-byte payload at the byte extremes.
                push_byte(START_MARK, 1'b1, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(8'h02, 1'b0, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
                push_byte(END_MARK, 1'b0, 1'b0, 1'b0);
                push_byte(8'h02, 1'b0, 1'b1, 1'b0);
                // Reception error, then a stray byte while waiting for a start.
                push_byte(8'hFF, 1'b1, 1'b1, 1'b1);
                push_byte(START_MARK, 1'b0, 1'b0, 1'b0);
                // Wrong start byte on a packet that ends early.
                push_byte(8'h00, 1'b1, 1'b0, 1'b0);
                push_byte(8'h11, 1'b0, 1'b0, 1'b0);
                push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
                // Packet ending right after the length byte.
                push_byte(START_MARK, 1'b1, 1'b0, 1'b0);
                push_byte(8'h01, 1'b0, 1'b0, 1'b0);
                push_byte(8'h00, 1'b0, 1'b0, 1'b0);
                push_byte(8'h05, 1'b0, 1'b1, 1'b0);
                wait_drained();
            end else begin
                set_own_address(addr_plan[ph]);
            end

            phase_bytes = 0;
            if (ph == PHASES - 1) begin
                queued_prior = rx_bytes_pending.size();
                queue_frame(255);
                phase_bytes += rx_bytes_pending.size() - queued_prior;
            end
            while (phase_bytes < BYTES_PER_PHASE) begin
                queued_prior = rx_bytes_pending.size();
                queue_frame(($urandom_range(0, 99) < 90) ? $urandom_range(0, 6)
                                                          : $urandom_range(7, 30));
                phase_bytes += rx_bytes_pending.size() - queued_prior;
                // Stray bytes between packets; they do not count as traffic.
                if ($urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0);
                    end
                end
            end
            wait_drained();
        end

        $display("Covered %0d frames in %0d phases: %0d bytes in, %0d payload items out",
                 frames_queued, PHASES, bytes_accepted, payload_seen);
        $display("Status items ok/start/end/addr/sum/rx: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[ST_OK], status_hits[ST_BAD_START], status_hits[ST_BAD_END],
                 status_hits[ST_NOT_MINE], status_hits[ST_BAD_SUM],
                 status_hits[ST_RX_FAILED]);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
